>>> src/bib_pkg.sv
// Shared types and constants for the breakpoint interval blend block.
`default_nettype none

package bib_pkg;

    localparam int TIME_W    = 32;
    localparam int IDX_W     = 6;
    localparam int CNT_W     = 7;
    localparam int FRAC_W    = 16;
    localparam int DIV_CNT_W = 4;

    typedef enum logic [0:0] {
        ACT_WRITE = 1'b0,
        ACT_QUERY = 1'b1
    } action_t;

    typedef enum logic [1:0] {
        ADDR_ZERO = 2'd0,
        ADDR_LAST = 2'd1,
        ADDR_NEXT = 2'd2,
        ADDR_PREV = 2'd3
    } addr_sel_t;

    typedef enum logic [2:0] {
        ST_IDLE      = 3'd0,
        ST_CHK_FIRST = 3'd1,
        ST_CHK_LAST  = 3'd2,
        ST_SCAN      = 3'd3,
        ST_LOAD_DIV  = 3'd4,
        ST_DIVIDE    = 3'd5,
        ST_FINISH    = 3'd6
    } state_t;

    typedef struct packed {
        logic      in_ready;
        addr_sel_t addr_sel;
        logic      idx_clr;
        logic      idx_inc;
        logic      cap_found;
        logic      res_zero;
        logic      res_last;
        logic      div_load;
        logic      div_step;
        logic      out_load;
    } cmd_t;

    typedef struct packed {
        logic in_query;
        logic k_le1;
        logic rd_gt_t;
        logic rd_ge_t;
        logic div_last;
        logic out_free;
    } status_t;

endpackage

`default_nettype wire

>>> src/bib_in_if.sv
// Input channel: table writes and time queries.
`default_nettype none

interface bib_in_if;
    logic                             valid;
    logic                             ready;
    logic                             action;
    logic [bib_pkg::IDX_W-1:0]        entry_index;
    logic signed [bib_pkg::TIME_W-1:0] time_value;

    modport source (output valid, action, entry_index, time_value, input ready);
    modport sink   (input valid, action, entry_index, time_value, output ready);
endinterface

`default_nettype wire

>>> src/bib_out_if.sv
// Output channel: interval indices and blend fraction.
`default_nettype none

interface bib_out_if;
    logic                       valid;
    logic                       ready;
    logic [bib_pkg::IDX_W-1:0]  lower_index;
    logic [bib_pkg::IDX_W-1:0]  upper_index;
    logic [bib_pkg::FRAC_W-1:0] fraction;

    modport source (output valid, lower_index, upper_index, fraction, input ready);
    modport sink   (input valid, lower_index, upper_index, fraction, output ready);
endinterface

`default_nettype wire

>>> src/bib_ctrl.sv
// Sequencer for the table search and the fraction division.
`default_nettype none

module bib_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire bib_pkg::status_t status,
    output bib_pkg::cmd_t         cmd
);

    bib_pkg::state_t state_reg;
    bib_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bib_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        cmd          = '0;
        cmd.addr_sel = bib_pkg::ADDR_ZERO;
        case (state_reg)
            bib_pkg::ST_IDLE:
            begin
                cmd.in_ready = 1'b1;
                if (status.in_query)
                begin
                    state_next = bib_pkg::ST_CHK_FIRST;
                end
            end
            bib_pkg::ST_CHK_FIRST:
            begin
                // read data holds the first time
                cmd.addr_sel = bib_pkg::ADDR_LAST;
                cmd.idx_clr  = 1'b1;
                if (status.k_le1 || status.rd_ge_t)
                begin
                    cmd.res_zero = 1'b1;
                    state_next   = bib_pkg::ST_FINISH;
                end
                else
                begin
                    state_next = bib_pkg::ST_CHK_LAST;
                end
            end
            bib_pkg::ST_CHK_LAST:
            begin
                cmd.addr_sel = bib_pkg::ADDR_NEXT;
                cmd.idx_inc  = 1'b1;
                if (!status.rd_gt_t)
                begin
                    cmd.res_last = 1'b1;
                    state_next   = bib_pkg::ST_FINISH;
                end
                else
                begin
                    state_next = bib_pkg::ST_SCAN;
                end
            end
            bib_pkg::ST_SCAN:
            begin
                // the last entry is known to be greater, so this ends
                if (status.rd_gt_t)
                begin
                    cmd.addr_sel  = bib_pkg::ADDR_PREV;
                    cmd.cap_found = 1'b1;
                    state_next    = bib_pkg::ST_LOAD_DIV;
                end
                else
                begin
                    cmd.addr_sel = bib_pkg::ADDR_NEXT;
                    cmd.idx_inc  = 1'b1;
                end
            end
            bib_pkg::ST_LOAD_DIV:
            begin
                cmd.div_load = 1'b1;
                state_next   = bib_pkg::ST_DIVIDE;
            end
            bib_pkg::ST_DIVIDE:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                begin
                    state_next = bib_pkg::ST_FINISH;
                end
            end
            bib_pkg::ST_FINISH:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = bib_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = bib_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> src/bib_dp.sv
// Datapath: sample table memory, search index, restoring divider, result register.
`default_nettype none

module bib_dp #(
    parameter int TABLE_DEPTH = 64
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         cfg_we,
    input  wire logic [bib_pkg::CNT_W-1:0]    cfg_wdata,
    bib_in_if.sink                            in_ch,
    bib_out_if.source                         out_ch,
    input  wire bib_pkg::cmd_t                cmd,
    output bib_pkg::status_t                  status
);

    localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int T_W    = bib_pkg::TIME_W;
    localparam int C_W    = bib_pkg::CNT_W;
    localparam int F_W    = bib_pkg::FRAC_W;
    localparam int D_W    = bib_pkg::DIV_CNT_W;
    localparam int I_W    = bib_pkg::IDX_W;

    logic [T_W-1:0] mem [TABLE_DEPTH];

    logic [C_W-1:0]    sample_count_reg;
    logic [T_W-1:0]    t_reg;
    logic [C_W-1:0]    k_reg;
    logic [C_W-1:0]    idx_reg;
    logic [T_W-1:0]    rdata_reg;
    logic [T_W-1:0]    thi_reg;
    logic [C_W-1:0]    lo_reg;
    logic [C_W-1:0]    hi_reg;
    logic [T_W:0]      rem_reg;
    logic [T_W:0]      span_reg;
    logic [F_W-1:0]    q_reg;
    logic [D_W-1:0]    div_cnt_reg;
    logic              out_valid_reg;
    logic [I_W-1:0]    out_lo_reg;
    logic [I_W-1:0]    out_hi_reg;
    logic [F_W-1:0]    out_frac_reg;

    logic              in_beat;
    logic [C_W-1:0]    k_next;
    logic [C_W-1:0]    rd_idx;
    logic [ADDR_W-1:0] rd_addr;
    logic [T_W+1:0]    rem_shift;
    logic [T_W+1:0]    rem_diff;
    logic [T_W:0]      diff_next;
    logic [T_W:0]      span_next;

    assign in_ch.ready = cmd.in_ready;
    assign in_beat     = in_ch.valid && cmd.in_ready;

    // table size seen by a query saturates at the depth
    always_comb
    begin
        if (int'(sample_count_reg) > TABLE_DEPTH)
        begin
            k_next = C_W'(TABLE_DEPTH);
        end
        else
        begin
            k_next = sample_count_reg;
        end
    end

    always_comb
    begin
        case (cmd.addr_sel)
            bib_pkg::ADDR_ZERO: rd_idx = '0;
            bib_pkg::ADDR_LAST: rd_idx = k_reg - C_W'(1);
            bib_pkg::ADDR_NEXT: rd_idx = idx_reg + C_W'(1);
            bib_pkg::ADDR_PREV: rd_idx = idx_reg - C_W'(1);
            default:            rd_idx = '0;
        endcase
    end

    assign rd_addr = ADDR_W'(rd_idx);

    always_ff @(posedge clk)
    begin
        if (in_beat && (in_ch.action == bib_pkg::ACT_WRITE)
            && (int'(in_ch.entry_index) < TABLE_DEPTH))
        begin
            mem[ADDR_W'(in_ch.entry_index)] <= in_ch.time_value;
        end
        rdata_reg <= mem[rd_addr];
    end

    assign status.in_query = in_ch.valid && (in_ch.action == bib_pkg::ACT_QUERY);
    assign status.k_le1    = (k_reg <= C_W'(1));
    assign status.rd_gt_t  = ($signed(rdata_reg) > $signed(t_reg));
    assign status.rd_ge_t  = ($signed(rdata_reg) >= $signed(t_reg));
    assign status.div_last = (div_cnt_reg == D_W'(F_W - 1));
    assign status.out_free = !out_valid_reg || out_ch.ready;

    // both differences are non-negative on the interior path
    assign diff_next = {t_reg[T_W-1], t_reg} - {rdata_reg[T_W-1], rdata_reg};
    assign span_next = {thi_reg[T_W-1], thi_reg} - {rdata_reg[T_W-1], rdata_reg};
    assign rem_shift = {rem_reg, 1'b0};
    assign rem_diff  = rem_shift - {1'b0, span_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_count_reg <= '0;
        end
        else if (cfg_we)
        begin
            sample_count_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_beat)
        begin
            t_reg <= in_ch.time_value;
            k_reg <= k_next;
        end
        if (cmd.idx_clr)
        begin
            idx_reg <= '0;
        end
        else if (cmd.idx_inc)
        begin
            idx_reg <= idx_reg + C_W'(1);
        end
        if (cmd.res_zero)
        begin
            lo_reg <= '0;
            hi_reg <= '0;
            q_reg  <= '0;
        end
        else if (cmd.res_last)
        begin
            lo_reg <= k_reg - C_W'(1);
            hi_reg <= k_reg - C_W'(1);
            q_reg  <= '0;
        end
        else if (cmd.cap_found)
        begin
            hi_reg  <= idx_reg;
            lo_reg  <= idx_reg - C_W'(1);
            thi_reg <= rdata_reg;
        end
        else if (cmd.div_load)
        begin
            rem_reg     <= diff_next;
            span_reg    <= span_next;
            q_reg       <= '0;
            div_cnt_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            if (!rem_diff[T_W+1])
            begin
                rem_reg <= rem_diff[T_W:0];
                q_reg   <= {q_reg[F_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_shift[T_W:0];
                q_reg   <= {q_reg[F_W-2:0], 1'b0};
            end
            div_cnt_reg <= div_cnt_reg + D_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_lo_reg   <= lo_reg[I_W-1:0];
            out_hi_reg   <= hi_reg[I_W-1:0];
            out_frac_reg <= q_reg;
        end
    end

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.lower_index = out_lo_reg;
    assign out_ch.upper_index = out_hi_reg;
    assign out_ch.fraction    = out_frac_reg;

endmodule

`default_nettype wire

>>> src/breakpoint_interval_blend.sv
// Top level of the breakpoint interval blend block.
//
// A write beat stores one sample time in the table; it gives no result. A
// query beat walks the table from the first entry to find the first sample
// greater than the query time, one memory read per cycle, then runs a
// 16-step restoring divider for the Q0.16 fraction. A query with fewer than
// two samples in use, at or before the first sample, or at or after the last
// sample skips the scan and the divider; an interior query scans up to its
// upper sample. A new beat is taken only once the query's result is loaded
// into the output register, and that result becomes valid as the block
// returns to idle. The single-port table read and the one-bit-per-cycle
// divider set how long a query takes. The result sits in an output register,
// so the next beat is taken while it waits. The user must write sample_count
// only while the block is idle; the block itself does not enforce it.
`default_nettype none

module breakpoint_interval_blend #(
    parameter int TABLE_DEPTH = 64
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      cfg_we,
    input  wire logic [bib_pkg::CNT_W-1:0] cfg_wdata,
    bib_in_if.sink                         in_ch,
    bib_out_if.source                      out_ch
);

    bib_pkg::cmd_t    cmd;
    bib_pkg::status_t status;

    bib_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .cmd    (cmd)
    );

    bib_dp #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

`default_nettype wire

>>> test/tb_top.sv
// Self-checking testbench for breakpoint_interval_blend: table loads, interval queries, stalls.
`timescale 1ns / 100ps

module tb_top;

    localparam int     DEPTH        = 64;
    localparam int     ITEM_TARGET  = 1650;
    localparam int     SETTLE_WAIT  = 120;
    localparam int     STALL_CYCLES = 400;
    localparam int     IDLE_LIMIT   = 4000;
    localparam longint TIME_MAX     = 64'sd2147483647;
    localparam longint TIME_MIN     = -64'sd2147483648;

    typedef enum {
        LOAD_NARROW,
        LOAD_WIDE,
        LOAD_UNORDERED
    } load_style_t;

    typedef struct packed {
        logic [bib_pkg::IDX_W-1:0]  lower;
        logic [bib_pkg::IDX_W-1:0]  upper;
        logic [bib_pkg::FRAC_W-1:0] fraction;
    } blend_t;

    logic                      clk;
    logic                      rst_n;
    logic                      cfg_we;
    logic [bib_pkg::CNT_W-1:0] cfg_wdata;

    bib_in_if  in_ch ();
    bib_out_if out_ch ();

    breakpoint_interval_blend #(
        .TABLE_DEPTH (DEPTH)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    // local copy of the block's table and count
    logic signed [bib_pkg::TIME_W-1:0] tbl_times [DEPTH];
    logic [bib_pkg::CNT_W-1:0]         count_setting = '0;

    blend_t pending_blends [$];
    blend_t want_blend;
    int     error_count   = 0;
    int     beats_sent    = 0;
    int     idle_cycles   = 0;
    int     hold_request  = 0;
    bit     in_gaps_on    = 1'b1;
    bit     out_stalls_on = 1'b1;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic logic signed [bib_pkg::TIME_W-1:0] clamp_time(longint v);
        if (v > TIME_MAX)
            return 32'h7FFF_FFFF;
        if (v < TIME_MIN)
            return 32'h8000_0000;
        return v[31:0];
    endfunction

    function automatic blend_t blend_for_time(logic signed [bib_pkg::TIME_W-1:0] t);
        int     k;
        int     hi;
        longint span;
        longint diff;
        longint q;
        blend_t r;
        r = '0;
        k = (count_setting > DEPTH) ? DEPTH : int'(count_setting);
        if (k <= 1 || t <= tbl_times[0])
            return r;
        if (t >= tbl_times[k - 1])
        begin
            r.lower = bib_pkg::IDX_W'(k - 1);
            r.upper = bib_pkg::IDX_W'(k - 1);
            return r;
        end
        // first entry above the query, ordered or not
        hi = k - 1;
        for (int i = 1; i < k; i++)
        begin
            if (tbl_times[i] > t)
            begin
                hi = i;
                break;
            end
        end
        r.lower = bib_pkg::IDX_W'(hi - 1);
        r.upper = bib_pkg::IDX_W'(hi);
        span = longint'(tbl_times[hi]) - longint'(tbl_times[hi - 1]);
        diff = longint'(t) - longint'(tbl_times[hi - 1]);
        if (span > 0 && diff >= 0)
        begin
            q = (diff * 65536) / span;
            r.fraction = (q > 65535) ? 16'hFFFF : q[15:0];
        end
        return r;
    endfunction

    task automatic flag_error(string what);
        error_count++;
        if (error_count <= 10)
            $display("%s", what);
    endtask

    task automatic send_beat(bib_pkg::action_t act, logic [bib_pkg::IDX_W-1:0] idx,
                             logic signed [bib_pkg::TIME_W-1:0] t);
        int gap;
        gap = in_gaps_on ? $urandom_range(0, 19) : 0;
        if (gap > 0)
        begin
            @(negedge clk);
            in_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_ch.valid       <= 1'b1;
        in_ch.action      <= act;
        in_ch.entry_index <= idx;
        in_ch.time_value  <= t;
        do @(posedge clk); while (!in_ch.ready);
        beats_sent++;
        if (act == bib_pkg::ACT_WRITE)
            tbl_times[idx] = t;
        else
            pending_blends = {pending_blends, blend_for_time(t)};
    endtask

    // wait until every result is back and the block has gone quiet
    task automatic settle();
        @(negedge clk);
        in_ch.valid <= 1'b0;
        while (pending_blends.size() != 0)
            @(posedge clk);
        repeat (SETTLE_WAIT) @(posedge clk);
    endtask

    task automatic write_sample_count(logic [bib_pkg::CNT_W-1:0] v);
        settle();
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(negedge clk);
        cfg_we    <= 1'b0;
        count_setting = v;
    endtask

    task automatic load_table(int n, load_style_t style);
        longint vals [DEPTH];
        longint v;
        longint step_max;
        bit     downward;
        downward = 1'($urandom_range(0, 1));
        step_max = (style == LOAD_WIDE) ? 64'sd4294967295 / n : 64'sd131072;
        v = (style == LOAD_WIDE) ? TIME_MIN + longint'($urandom_range(0, 65535))
                                 : longint'($signed($urandom));
        for (int i = 0; i < n; i++)
        begin
            if (style == LOAD_UNORDERED)
                vals[i] = longint'($signed($urandom));
            else
            begin
                vals[i] = v;
                // occasional zero step gives repeated times
                if ($urandom_range(0, 7) != 0)
                    v = v + longint'($urandom) % (step_max + 1);
                if (v > TIME_MAX)
                    v = TIME_MAX;
            end
        end
        for (int i = 0; i < n; i++)
        begin
            if (downward)
                send_beat(bib_pkg::ACT_WRITE, bib_pkg::IDX_W'(n - 1 - i),
                          vals[n - 1 - i][31:0]);
            else
                send_beat(bib_pkg::ACT_WRITE, bib_pkg::IDX_W'(i), vals[i][31:0]);
        end
    endtask

    // query times aimed at entries, gaps between them, the ends of the table, or anywhere
    function automatic logic signed [bib_pkg::TIME_W-1:0] pick_query_time(int k);
        int                                kk;
        int                                j;
        longint                            lo_t;
        longint                            hi_t;
        logic signed [bib_pkg::TIME_W-1:0] t;
        kk = (k < 1) ? 1 : ((k > DEPTH) ? DEPTH : k);
        case ($urandom_range(0, 9))
            0, 1, 2: t = tbl_times[$urandom_range(0, kk - 1)];
            3, 4, 5:
            begin
                j    = (kk > 1) ? int'($urandom_range(0, kk - 2)) : 0;
                lo_t = longint'(tbl_times[j]);
                hi_t = longint'(tbl_times[(kk > 1) ? j + 1 : 0]);
                if (hi_t > lo_t)
                    t = clamp_time(lo_t + longint'($urandom) % (hi_t - lo_t));
                else
                    t = lo_t[31:0];
            end
            6: t = clamp_time(longint'(tbl_times[0]) - longint'($urandom_range(1, 'h40000)));
            7: t = clamp_time(longint'(tbl_times[kk - 1])
                              + longint'($urandom_range(0, 'h40000)));
            default: t = $urandom;
        endcase
        return t;
    endfunction

    task automatic test_directed_edges();
        send_beat(bib_pkg::ACT_WRITE, 6'd0,  32'hFFFF_0000);
        send_beat(bib_pkg::ACT_WRITE, 6'd1,  32'h0000_0000);
        send_beat(bib_pkg::ACT_WRITE, 6'd2,  32'h0001_0000);
        send_beat(bib_pkg::ACT_WRITE, 6'd3,  32'hFFFF_8000);     // dip: table out of order
        send_beat(bib_pkg::ACT_WRITE, 6'd4,  32'h7FFF_FFFF);
        send_beat(bib_pkg::ACT_WRITE, 6'd63, 32'h8000_0000);
        send_beat(bib_pkg::ACT_WRITE, 6'd42, 32'h5A5A_A5A5);
        // empty and single-entry tables
        send_beat(bib_pkg::ACT_QUERY, 6'd63, 32'h0001_0000);
        send_beat(bib_pkg::ACT_QUERY, 6'd0,  32'h8000_0000);
        write_sample_count(7'd1);
        send_beat(bib_pkg::ACT_QUERY, 6'd21, 32'h7FFF_FFFF);
        write_sample_count(7'd5);
        send_beat(bib_pkg::ACT_QUERY, 6'd0,  32'h8000_0000);
        send_beat(bib_pkg::ACT_QUERY, 6'd0,  32'hFFFF_0000);
        send_beat(bib_pkg::ACT_QUERY, 6'd0,  32'hFFFF_8000);
        send_beat(bib_pkg::ACT_QUERY, 6'd0,  32'h0000_0000);
        send_beat(bib_pkg::ACT_QUERY, 6'd0,  32'h0000_8000);
        send_beat(bib_pkg::ACT_QUERY, 6'd0,  32'h0001_0000);
        send_beat(bib_pkg::ACT_QUERY, 6'd0,  32'h7FFF_FFFE);
        send_beat(bib_pkg::ACT_QUERY, 6'd0,  32'h7FFF_FFFF);
    endtask

    task automatic test_backpressure();
        in_gaps_on    = 1'b0;
        out_stalls_on = 1'b0;
        write_sample_count(7'd64);
        load_table(DEPTH, LOAD_NARROW);
        hold_request = STALL_CYCLES;
        repeat (16)
            send_beat(bib_pkg::ACT_QUERY, bib_pkg::IDX_W'($urandom), pick_query_time(DEPTH));
        in_gaps_on    = 1'b1;
        out_stalls_on = 1'b1;
    endtask

    task automatic test_random_tables();
        int          forced [5] = '{2, 64, 127, 1, 0};
        int          phase;
        int          cnt;
        int          eff;
        load_style_t style;
        phase = 0;
        while (beats_sent < ITEM_TARGET)
        begin
            if (phase < 5)
                cnt = forced[phase];
            else
            begin
                case ($urandom_range(0, 9))
                    0:       cnt = $urandom_range(0, 1);
                    1, 2:    cnt = $urandom_range(13, 64);
                    3:       cnt = $urandom_range(65, 127);
                    default: cnt = $urandom_range(2, 12);
                endcase
            end
            case ($urandom_range(0, 3))
                0: {in_gaps_on, out_stalls_on} = 2'b11;
                1: {in_gaps_on, out_stalls_on} = 2'b10;
                2: {in_gaps_on, out_stalls_on} = 2'b01;
                default: {in_gaps_on, out_stalls_on} = 2'b00;
            endcase
            write_sample_count(cnt[6:0]);
            eff = (cnt > DEPTH) ? DEPTH : cnt;
            case ($urandom_range(0, 9))
                0:       style = LOAD_UNORDERED;
                1, 2, 3: style = LOAD_WIDE;
                default: style = LOAD_NARROW;
            endcase
            load_table((eff < 1) ? 1 : eff, style);
            repeat ($urandom_range(25, 45))
            begin
                // stray writes land anywhere, disturbing the order now and then
                if ($urandom_range(0, 11) == 0)
                    send_beat(bib_pkg::ACT_WRITE, bib_pkg::IDX_W'($urandom), $urandom);
                else
                    send_beat(bib_pkg::ACT_QUERY, bib_pkg::IDX_W'($urandom),
                              pick_query_time(eff));
            end
            phase++;
        end
    endtask

    initial
    begin : result_sink
        int stall;
        out_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            stall = out_stalls_on ? $urandom_range(0, 19) : 0;
            if (hold_request > 0)
            begin
                stall = hold_request;
                hold_request = 0;
            end
            repeat (stall) @(negedge clk) out_ch.ready <= 1'b0;
            @(negedge clk);
            out_ch.ready <= 1'b1;
            do @(posedge clk); while (!out_ch.valid);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (pending_blends.size() == 0)
                flag_error($sformatf("%0t: unexpected beat lower %0d upper %0d fraction 0x%04h",
                                     $time, out_ch.lower_index, out_ch.upper_index,
                                     out_ch.fraction));
            else
            begin
                want_blend = pending_blends.pop_front();
                if (out_ch.lower_index !== want_blend.lower
                    || out_ch.upper_index !== want_blend.upper
                    || out_ch.fraction !== want_blend.fraction)
                    flag_error($sformatf({"%0t: expected lower %0d upper %0d fraction 0x%04h,",
                                          " got lower %0d upper %0d fraction 0x%04h"},
                                         $time, want_blend.lower, want_blend.upper,
                                         want_blend.fraction, out_ch.lower_index,
                                         out_ch.upper_index, out_ch.fraction));
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("** breakpoint_interval_blend: FAILED **");
                $finish;
            end
        end
    end

    initial
    begin
        in_ch.valid       = 1'b0;
        in_ch.action      = bib_pkg::ACT_WRITE;
        in_ch.entry_index = '0;
        in_ch.time_value  = '0;
        cfg_we            = 1'b0;
        cfg_wdata         = '0;
        rst_n             = 1'b0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed_edges();
        test_backpressure();
        test_random_tables();
        settle();

        if (error_count == 0 && pending_blends.size() == 0)
            $display("** breakpoint_interval_blend: PASSED **");
        else
            $display("** breakpoint_interval_blend: FAILED **");
        $finish;
    end

endmodule

>>> filelist.f
src/bib_pkg.sv
src/bib_in_if.sv
src/bib_out_if.sv
src/bib_ctrl.sv
src/bib_dp.sv
src/breakpoint_interval_blend.sv
test/tb_top.sv
